// File: rtl/nfba_pkg.sv
package nfba_pkg;

  localparam int DEF_MAX_BLOCKS = 2048;

  localparam int CFG_W = 12;
  localparam int IDX_W = 11;
  localparam int CNT_W = 12;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [CFG_W-1:0] RESET_BLOCKS = 12'd1760;

  // blocks 0 and 1 are never handed out
  localparam int RSV_BLOCKS = 2;
  localparam int MIN_VOLUME = 3;

  // map row width
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic latch;
    logic idx_read;
    logic scan_init;
    logic scan_read;
    logic fin_direct;
    logic fin_word;
    logic fin_hit;
    logic fin_miss;
    logic out_load;
  } nfba_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic            data_valid;
    logic            scan_hit;
    logic            scan_done;
  } nfba_stat_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic             enough_free;
    logic [CNT_W-1:0] free_total;
    logic             block_is_free;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] granted_block;
  } nfba_res_t;

endpackage

// File: rtl/nfba_ctrl.sv
module nfba_ctrl import nfba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  nfba_stat_t stat,
  output nfba_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PUSH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (stat.op == OP_ALLOC) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else if (stat.op == OP_CHECK || !stat.idx_ok) begin
          cmd.fin_direct = 1'b1;
          state_next     = S_PUSH;
        end else begin
          cmd.idx_read = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.fin_word = 1'b1;
        state_next   = S_PUSH;
      end
      S_SCAN: begin
        priority if (stat.scan_hit) begin
          cmd.fin_hit = 1'b1;
          state_next  = S_PUSH;
        end else if (stat.scan_done && !stat.data_valid) begin
          cmd.fin_miss = 1'b1;
          state_next   = S_PUSH;
        end else begin
          // keep one row read in flight per cycle
          cmd.scan_read = !stat.scan_done;
        end
      end
      S_PUSH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/nfba_datapath.sv
module nfba_datapath import nfba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IDX_W-1:0] in_idx,
  input  logic [CNT_W-1:0] in_wanted,
  input  nfba_cmd_t        cmd,
  output nfba_stat_t       stat,
  output nfba_res_t        out_res
);

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int ROWS      = 2 ** WA_W;
  localparam int PTR_W     = WA_W + BIT_W;
  localparam int VIS_W     = WA_W + 1;

  function automatic logic [CFG_W-1:0] sat_volume(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (32'(v) > MAX_BLOCKS) begin
      r = CFG_W'(MAX_BLOCKS);
    end else if (32'(v) < MIN_VOLUME) begin
      r = CFG_W'(MIN_VOLUME);
    end
    return r;
  endfunction

  // contents of a row that has not been written since format
  function automatic logic [WORD_W-1:0] reset_word(input logic [WA_W-1:0] row,
                                                   input logic [CFG_W-1:0] vol);
    logic [WORD_W-1:0] w;
    logic [PTR_W-1:0]  b;
    w = '0;
    for (int j = 0; j < WORD_W; j++) begin
      b    = {row, BIT_W'(j)};
      w[j] = (32'(b) >= RSV_BLOCKS) && (32'(b) < 32'(vol));
    end
    return w;
  endfunction

  logic [CFG_W-1:0]  volume;
  logic [PTR_W-1:0]  ptr;
  logic [CNT_W-1:0]  free_cnt;
  logic [ROWS-1:0]   row_valid;
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] mem_q;
  logic              vld_q;
  logic [WA_W-1:0]   row_q;
  logic              first_q;
  logic              dv_q;
  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  wanted_q;
  logic [WA_W-1:0]   rd_row;
  logic [VIS_W-1:0]  visits;
  nfba_res_t         res_q;

  logic [CFG_W-1:0]  vol_cfg;
  logic [WORD_W-1:0] eff_word;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] cand;
  logic [BIT_W-1:0]  pos;
  logic [PTR_W-1:0]  found;
  logic [PTR_W-1:0]  found_next;
  logic [PTR_W-1:0]  idx_blk;
  logic [PTR_W-1:0]  vol_m1;
  logic [WA_W-1:0]   last_row;
  logic [VIS_W-1:0]  visit_total;
  logic              idx_ok;
  logic              free_do;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [WA_W-1:0]   rd_addr;
  nfba_res_t         res_next;

  assign vol_cfg     = sat_volume(cfg_data);
  assign eff_word    = vld_q ? mem_q : reset_word(row_q, volume);
  assign scan_mask   = first_q ? ({WORD_W{1'b1}} << ptr[BIT_W-1:0]) : {WORD_W{1'b1}};
  assign cand        = eff_word & scan_mask;
  assign found       = {row_q, pos};
  assign found_next  = (32'(found) + 32'd1 < 32'(volume)) ? found + PTR_W'(1) : '0;
  assign idx_blk     = PTR_W'(idx_q);
  assign idx_ok      = 32'(idx_q) < 32'(volume);
  assign vol_m1      = PTR_W'(32'(volume) - 32'd1);
  assign last_row    = vol_m1[PTR_W-1:BIT_W];
  assign visit_total = VIS_W'(last_row) + VIS_W'(2);

  // lowest free bit of the row under inspection
  always_comb begin
    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

  assign free_do = cmd.fin_word && (op_q == OP_FREE) && (32'(idx_q) >= RSV_BLOCKS)
                   && !eff_word[idx_blk[BIT_W-1:0]];
  assign wr_en   = cmd.fin_hit || free_do;
  assign wr_data = cmd.fin_hit ? (eff_word & ~(WORD_W'(1) << pos))
                               : (eff_word | (WORD_W'(1) << idx_blk[BIT_W-1:0]));
  assign rd_en   = cmd.idx_read || cmd.scan_read;
  assign rd_addr = cmd.scan_read ? rd_row : idx_blk[PTR_W-1:BIT_W];

  always_comb begin
    stat.op         = op_q;
    stat.idx_ok     = idx_ok;
    stat.data_valid = dv_q;
    stat.scan_hit   = dv_q && (|cand);
    stat.scan_done  = (visits == visit_total);
  end

  always_comb begin
    res_next               = '0;
    res_next.free_total    = free_cnt;
    if (cmd.fin_hit) begin
      res_next.granted_block = IDX_W'(found);
      res_next.free_total    = free_cnt - CNT_W'(1);
    end else if (cmd.fin_miss) begin
      res_next.status = ST_NOSPACE;
    end else if (cmd.fin_word) begin
      res_next.block_is_free = (op_q == OP_QUERY) && (32'(idx_q) >= RSV_BLOCKS)
                               && eff_word[idx_blk[BIT_W-1:0]];
      if (free_do) begin
        res_next.free_total = free_cnt + CNT_W'(1);
      end
    end else if (op_q == OP_CHECK) begin
      res_next.enough_free = (wanted_q <= free_cnt);
    end else begin
      res_next.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume    <= sat_volume(RESET_BLOCKS);
      ptr       <= '0;
      free_cnt  <= CNT_W'(sat_volume(RESET_BLOCKS)) - CNT_W'(RSV_BLOCKS);
      row_valid <= '0;
      dv_q      <= 1'b0;
    end else begin
      dv_q <= rd_en;
      if (cfg_valid) begin
        // reformat: unwritten rows read back as their reset pattern
        volume    <= vol_cfg;
        ptr       <= '0;
        free_cnt  <= CNT_W'(vol_cfg) - CNT_W'(RSV_BLOCKS);
        row_valid <= '0;
      end else begin
        if (wr_en) begin
          row_valid[row_q] <= 1'b1;
        end
        if (cmd.fin_hit) begin
          ptr      <= found_next;
          free_cnt <= free_cnt - CNT_W'(1);
        end else if (free_do) begin
          free_cnt <= free_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_q] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= in_op;
      idx_q    <= in_idx;
      wanted_q <= in_wanted;
    end
    if (rd_en) begin
      vld_q   <= row_valid[rd_addr];
      row_q   <= rd_addr;
      first_q <= cmd.scan_read && (visits == '0);
    end
    if (cmd.scan_init) begin
      rd_row <= ptr[PTR_W-1:BIT_W];
      visits <= '0;
    end else if (cmd.scan_read) begin
      rd_row <= (rd_row == last_row) ? '0 : rd_row + WA_W'(1);
      visits <= visits + VIS_W'(1);
    end
    if (cmd.fin_direct || cmd.fin_word || cmd.fin_hit || cmd.fin_miss) begin
      res_q <= res_next;
    end
    if (cmd.out_load) begin
      out_res <= res_q;
    end
  end

endmodule

// File: rtl/next_fit_block_allocator_core.sv
// next-fit block allocator over a bitmap of storage blocks
// s_axis carries one operation per beat: tuser is the op code, tdata holds the
// block index and the wanted count. m_axis returns exactly one result beat per
// operation, in order. cfg_data sets the volume size; a write reformats the
// volume (all blocks free except 0 and 1, pointer back to 0) and is always
// taken; the user must write it only while no operation is in progress, which
// the block itself does not enforce. check and out-of-range free/query go
// from the decide state straight to the push state; free/query first read and
// evaluate the index's map row; allocate scans map rows from the pointer's row
// until it finds a free block, and reports out of space after visiting every
// row once and the starting row again. the scan reads one 32-bit row of the
// map per cycle from a memory with one read port, which sets the allocate time.
// one operation is worked on at a time; s_axis_tready returns the cycle after
// the result enters the output register, so a new beat is accepted while the
// previous result still waits on a stalled m_axis. a stalled receiver holds
// the next result in the block until the output register frees up.
// reset restores the default volume of 1760 blocks with no clearing pass.
module next_fit_block_allocator_core import nfba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // block_index[10:0], wanted_count[22:11], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // granted_block[10:0], status[12:11], block_is_free[13], free_total[25:14],
  // enough_free[26], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  nfba_cmd_t  cmd;
  nfba_stat_t stat;
  nfba_res_t  out_res;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = OUT_DATA_W'(out_res);

  nfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser),
    .in_idx    (s_axis_tdata[IDX_W-1:0]),
    .in_wanted (s_axis_tdata[IDX_W+CNT_W-1:IDX_W]),
    .cmd       (cmd),
    .stat      (stat),
    .out_res   (out_res)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new operation taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten before it was taken");

  a_hit_stops_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_hit |-> (!cmd.scan_read && !cmd.idx_read))
    else $error("map read issued on the cycle of a grant");

  a_nospace_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.status == ST_NOSPACE) |-> (out_res.granted_block == '0))
    else $error("block granted with out-of-space status");

endmodule
